[sv/csr_pkg.sv]
`timescale 1ns / 1ps
package csr_pkg;

  // key codes
  localparam logic [7:0] KEY_INC    = 8'd1;
  localparam logic [7:0] KEY_DEC    = 8'd2;
  localparam logic [7:0] KEY_NEXT   = 8'd3;
  localparam logic [7:0] KEY_PREV   = 8'd4;
  localparam logic [7:0] KEY_MODE   = 8'd5;
  localparam logic [7:0] KEY_INC10  = 8'd6;
  localparam logic [7:0] KEY_DEC10  = 8'd7;

  // configuration port geometry
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 14;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SET_MIN          = 3'd0,
    CFG_SET_MAX          = 3'd1,
    CFG_DAC_CEILING      = 3'd2,
    CFG_DAC_FLOOR        = 3'd3,
    CFG_EDIT_DAC_CODE    = 3'd4,
    CFG_DEFAULT_SETPOINT = 3'd5
  } csr_reg_t;

  // decimal weights and limits
  localparam logic [13:0] W_ONE      = 14'd1;
  localparam logic [13:0] W_TEN      = 14'd10;
  localparam logic [13:0] W_HUNDRED  = 14'd100;
  localparam logic [13:0] W_THOUSAND = 14'd1000;
  localparam logic [13:0] SETPOINT_TOP = 14'd9999;

  // reset values
  localparam logic [13:0] RST_SET_MIN   = 14'd20;
  localparam logic [13:0] RST_SET_MAX   = 14'd2000;
  localparam logic [7:0]  RST_CEILING   = 8'd230;
  localparam logic [7:0]  RST_FLOOR     = 8'd1;
  localparam logic [7:0]  RST_EDIT_DAC  = 8'd10;

  typedef logic [3:0] bcd_t;
  typedef logic [3:0][3:0] bcd4_t;

  localparam bcd4_t RST_SETPOINT = {4'd0, 4'd0, 4'd2, 4'd0};

  // configuration as seen by the regulator core
  typedef struct packed {
    logic [13:0] set_min;
    logic [13:0] set_max;
    logic [7:0]  dac_ceiling;
    logic [7:0]  dac_floor;
    logic [7:0]  edit_dac_code;
    bcd4_t       def_digits;
    logic        conv_busy;
  } csr_cfg_t;

  // digits of the measured current
  typedef struct packed {
    logic [1:0] thousands;
    bcd_t       hundreds;
    bcd_t       tens;
  } csr_meas_t;

  // one result word
  typedef struct packed {
    logic [7:0] dac_code;
    bcd4_t      set_digits;
    logic [1:0] cursor_pos;
    logic       running;
    csr_meas_t  meas;
  } csr_result_t;

  // binary value of four decimal digits
  function automatic logic [13:0] bcd_value(bcd4_t d);
    return 14'(d[3]) * W_THOUSAND + 14'(d[2]) * W_HUNDRED +
           14'(d[1]) * W_TEN + 14'(d[0]);
  endfunction

  // setpoint / 10, rounded half up
  function automatic logic [9:0] target_of(bcd4_t d);
    return 10'(d[3]) * 10'd100 + 10'(d[2]) * 10'd10 + 10'(d[1]) +
           ((d[0] >= 4'd5) ? 10'd1 : 10'd0);
  endfunction

  // clamp target into the dac range
  function automatic logic [7:0] sat8(logic [9:0] t);
    return (t > 10'd255) ? 8'hFF : t[7:0];
  endfunction

  // decimal add or subtract of one unit at digit position p
  function automatic bcd4_t bcd_adjust(bcd4_t d, logic [1:0] p, logic up);
    bcd4_t r;
    logic  c;
    r = d;
    c = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == p) c = 1'b1;
      if (c) begin
        if (up) begin
          if (d[i] == 4'd9) begin
            r[i] = 4'd0;
          end else begin
            r[i] = d[i] + 4'd1;
            c = 1'b0;
          end
        end else begin
          if (d[i] == 4'd0) begin
            r[i] = 4'd9;
          end else begin
            r[i] = d[i] - 4'd1;
            c = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  // decimal digit of rem at weight w, by parallel compares
  function automatic bcd_t digit_at(logic [13:0] rem, logic [13:0] w);
    bcd_t d;
    d = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (rem >= 14'(j) * w) d = 4'(j);
    end
    return d;
  endfunction

  // digits of sample * 10 (ones digit is always zero)
  function automatic csr_meas_t meas_split(logic [7:0] s);
    csr_meas_t m;
    logic [7:0] r;
    bcd_t       t;
    if (s >= 8'd200) begin
      m.thousands = 2'd2;
      r = s - 8'd200;
    end else if (s >= 8'd100) begin
      m.thousands = 2'd1;
      r = s - 8'd100;
    end else begin
      m.thousands = 2'd0;
      r = s;
    end
    t = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (r >= 8'(j * 10)) t = 4'(j);
    end
    m.hundreds = t;
    m.tens = 4'(r - 8'(t) * 8'd10);
    return m;
  endfunction

endpackage

[sv/csr_cfg.sv]
`timescale 1ns / 1ps
module csr_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [csr_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [csr_pkg::CFG_DW-1:0]  cfg_wdata,
  output csr_pkg::csr_cfg_t           cfg
);
  import csr_pkg::*;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_TENS,
    CONV_HUNDREDS,
    CONV_THOUSANDS
  } conv_state_t;

  conv_state_t state_r, state_nxt;
  logic [13:0] set_min_r, set_min_nxt;
  logic [13:0] set_max_r, set_max_nxt;
  logic [7:0]  ceil_r, ceil_nxt;
  logic [7:0]  floor_r, floor_nxt;
  logic [7:0]  edit_dac_r, edit_dac_nxt;
  bcd4_t       def_r, def_nxt;
  logic [13:0] rem_r, rem_nxt;

  bcd_t d_th, d_hu, d_te;

  // one decimal digit per cycle out of the remainder
  assign d_th = digit_at(rem_r, W_THOUSAND);
  assign d_hu = digit_at(rem_r, W_HUNDRED);
  assign d_te = digit_at(rem_r, W_TEN);

  always_comb begin
    state_nxt    = state_r;
    set_min_nxt  = set_min_r;
    set_max_nxt  = set_max_r;
    ceil_nxt     = ceil_r;
    floor_nxt    = floor_r;
    edit_dac_nxt = edit_dac_r;
    def_nxt      = def_r;
    rem_nxt      = rem_r;

    // default setpoint to digits conversion
    unique case (state_r)
      CONV_THOUSANDS: begin
        def_nxt[3] = d_th;
        rem_nxt    = rem_r - 14'(d_th) * W_THOUSAND;
        state_nxt  = CONV_HUNDREDS;
      end
      CONV_HUNDREDS: begin
        def_nxt[2] = d_hu;
        rem_nxt    = rem_r - 14'(d_hu) * W_HUNDRED;
        state_nxt  = CONV_TENS;
      end
      CONV_TENS: begin
        def_nxt[1] = d_te;
        def_nxt[0] = 4'(rem_r - 14'(d_te) * W_TEN);
        state_nxt  = CONV_IDLE;
      end
      default: ;
    endcase

    // register writes
    if (cfg_we) begin
      unique case (csr_reg_t'(cfg_addr))
        CFG_SET_MIN:       set_min_nxt  = cfg_wdata;
        CFG_SET_MAX:       set_max_nxt  = cfg_wdata;
        CFG_DAC_CEILING:   ceil_nxt     = cfg_wdata[7:0];
        CFG_DAC_FLOOR:     floor_nxt    = cfg_wdata[7:0];
        CFG_EDIT_DAC_CODE: edit_dac_nxt = cfg_wdata[7:0];
        CFG_DEFAULT_SETPOINT: begin
          rem_nxt   = (cfg_wdata > SETPOINT_TOP) ? SETPOINT_TOP : cfg_wdata;
          state_nxt = CONV_THOUSANDS;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CONV_IDLE;
      set_min_r  <= RST_SET_MIN;
      set_max_r  <= RST_SET_MAX;
      ceil_r     <= RST_CEILING;
      floor_r    <= RST_FLOOR;
      edit_dac_r <= RST_EDIT_DAC;
      def_r      <= RST_SETPOINT;
    end else begin
      state_r    <= state_nxt;
      set_min_r  <= set_min_nxt;
      set_max_r  <= set_max_nxt;
      ceil_r     <= ceil_nxt;
      floor_r    <= floor_nxt;
      edit_dac_r <= edit_dac_nxt;
      def_r      <= def_nxt;
      rem_r      <= rem_nxt;
    end
  end

  assign cfg.set_min       = set_min_r;
  assign cfg.set_max       = set_max_r;
  assign cfg.dac_ceiling   = ceil_r;
  assign cfg.dac_floor     = floor_r;
  assign cfg.edit_dac_code = edit_dac_r;
  assign cfg.def_digits    = def_r;
  assign cfg.conv_busy     = (state_r != CONV_IDLE);

  // a default setpoint write always starts a full conversion
  a_conv_start: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == CFG_DEFAULT_SETPOINT) |=> state_r == CONV_THOUSANDS)
    else $error("conversion did not start");

  // converted default digits stay decimal once idle
  a_def_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CONV_IDLE |-> (def_r[3] <= 4'd9) && (def_r[2] <= 4'd9) &&
                             (def_r[1] <= 4'd9) && (def_r[0] <= 4'd9))
    else $error("default digit out of range");

  // conversion steps down through the places in order
  a_conv_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CONV_HUNDREDS && !cfg_we |=> state_r == CONV_TENS)
    else $error("conversion skipped a place");

endmodule

[sv/csr_core.sv]
`timescale 1ns / 1ps
module csr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           action,
  input  logic [7:0]           sample,
  input  csr_pkg::csr_cfg_t    cfg,
  output csr_pkg::csr_result_t res
);
  import csr_pkg::*;

  bcd4_t      dig_r, dig_nxt;
  logic [1:0] cur_r, cur_nxt;
  logic       run_r, run_nxt;
  logic [7:0] drv_r, drv_nxt;

  logic [13:0] sp;
  logic [9:0]  tgt;
  bcd_t        cur_d, new_d;
  bcd4_t       tmp;
  logic [13:0] tmp_val;
  logic        in_lim;
  logic [7:0]  drv_trk;
  logic [1:0]  step_p;
  logic [13:0] step_w;
  logic        step_up, step_en;
  logic [13:0] sum_up;
  logic        step_ok;
  bcd4_t       dig_step;
  logic [9:0]  tgt_step;
  logic [7:0]  dac;
  csr_meas_t   meas;

  assign sp  = bcd_value(dig_r);
  assign tgt = target_of(dig_r);

  // edit mode: step the digit under the cursor, check the limits
  always_comb begin
    cur_d = dig_r[cur_r];
    if (action == KEY_INC) begin
      new_d = (cur_d >= 4'd9) ? 4'd0 : cur_d + 4'd1;
    end else begin
      new_d = (cur_d == 4'd0) ? 4'd9 : cur_d - 4'd1;
    end
    tmp = dig_r;
    tmp[cur_r] = new_d;
  end

  assign tmp_val = bcd_value(tmp);
  assign in_lim  = (tmp_val >= cfg.set_min) && (tmp_val <= cfg.set_max);

  // run mode: drive code tracks the target one count per pass
  always_comb begin
    drv_trk = drv_r;
    if ({2'b00, sample} < tgt) begin
      if (drv_r < cfg.dac_ceiling) drv_trk = drv_r + 8'd1;
    end else if ({2'b00, sample} > tgt) begin
      if (drv_r > cfg.dac_floor) drv_trk = drv_r - 8'd1;
    end
  end

  // run mode key decode: place, direction
  always_comb begin
    step_p  = 2'd0;
    step_w  = W_ONE;
    step_up = 1'b0;
    step_en = 1'b1;
    unique case (action) inside
      KEY_INC:   step_up = 1'b1;
      KEY_DEC:   ;
      KEY_NEXT:  begin step_p = 2'd2; step_w = W_HUNDRED; step_up = 1'b1; end
      KEY_PREV:  begin step_p = 2'd2; step_w = W_HUNDRED; end
      KEY_INC10: begin step_p = 2'd1; step_w = W_TEN; step_up = 1'b1; end
      KEY_DEC10: begin step_p = 2'd1; step_w = W_TEN; end
      default:   step_en = 1'b0;
    endcase
  end

  assign sum_up = sp + step_w;
  assign step_ok = step_up ? ((sum_up <= cfg.set_max) && (sum_up <= SETPOINT_TOP))
                           : ({1'b0, sp} >= {1'b0, cfg.set_min} + {1'b0, step_w});
  assign dig_step = step_ok ? bcd_adjust(dig_r, step_p, step_up) : dig_r;
  assign tgt_step = target_of(dig_step);
  assign meas     = meas_split(sample);

  // next state and result
  always_comb begin
    dig_nxt = dig_r;
    cur_nxt = cur_r;
    run_nxt = run_r;
    drv_nxt = drv_r;
    dac     = cfg.edit_dac_code;
    res.meas = '0;
    if (!run_r) begin
      unique case (action) inside
        KEY_INC, KEY_DEC: if (in_lim) dig_nxt = tmp;
        KEY_NEXT: cur_nxt = cur_r + 2'd1;
        KEY_PREV: cur_nxt = cur_r - 2'd1;
        KEY_MODE: begin
          run_nxt = 1'b1;
          drv_nxt = sat8(tgt);
        end
        default: ;
      endcase
    end else begin
      dac      = drv_trk;
      res.meas = meas;
      drv_nxt  = drv_trk;
      if (action == KEY_MODE) begin
        dig_nxt = cfg.def_digits;
        cur_nxt = 2'd0;
        run_nxt = 1'b0;
        drv_nxt = cfg.edit_dac_code;
      end else if (step_en) begin
        dig_nxt = dig_step;
        drv_nxt = sat8(tgt_step);
      end
    end
    res.dac_code   = dac;
    res.set_digits = dig_nxt;
    res.cursor_pos = cur_nxt;
    res.running    = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r <= RST_SETPOINT;
      cur_r <= 2'd0;
      run_r <= 1'b0;
      drv_r <= RST_EDIT_DAC;
    end else if (fire) begin
      dig_r <= dig_nxt;
      cur_r <= cur_nxt;
      run_r <= run_nxt;
      drv_r <= drv_nxt;
    end
  end

  // setpoint digits stay decimal
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_r[3] <= 4'd9) && (dig_r[2] <= 4'd9) && (dig_r[1] <= 4'd9) && (dig_r[0] <= 4'd9))
    else $error("setpoint digit out of range");

  // mode key in edit enters run
  a_enter_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !run_r && (action == KEY_MODE) |=> run_r)
    else $error("mode key did not enter run");

  // mode key in run returns to edit with cursor home
  a_enter_edit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && run_r && (action == KEY_MODE) |=> !run_r && (cur_r == 2'd0))
    else $error("mode key did not return to edit");

  // cursor only moves in edit mode, apart from going home on the mode key in run
  a_cursor_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && run_r && (action != KEY_MODE) |=> $stable(cur_r))
    else $error("cursor moved in run mode");

endmodule

[sv/current_setpoint_regulator_unit.sv]
`timescale 1ns / 1ps
// Current setpoint regulator: one input word is one pass of the control loop
// (key code and ADC sample); every word gives exactly one result word with the
// DAC code, the setpoint digits, cursor, mode and the measured current digits.
// Input channel: in_valid / in_stall with in_action, in_adc_sample.
// Result channel: out_valid / out_stall with the out_ fields.
// Configuration: cfg_we, cfg_addr (register index), cfg_wdata; write only while
// no word is in flight.
// A word accepted into the input register runs its pass when fire is high, and
// the pass loads the result register that drives the out_ ports. Throughput
// is one word per cycle while out_stall is low and no digit conversion runs,
// set by the single pass between the input register and the result register;
// the input register takes one new word while the last result waits to be taken.
// A write to the default setpoint starts a digit conversion through the
// thousands, hundreds and tens steps; during it the word in the input register
// waits, so the pass after such a write is held until the conversion is done.
// Reset (rst_n low at a clock edge) empties both registers, loads the register
// defaults, edit mode, cursor 0, setpoint 0020 and drive code 10.
// While out_stall is high the result holds, one more word is taken into the
// input register and then in_stall rises.
module current_setpoint_regulator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_action,
  input  logic [7:0]                  in_adc_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_dac_code,
  output logic [3:0]                  out_set_thousands,
  output logic [3:0]                  out_set_hundreds,
  output logic [3:0]                  out_set_tens,
  output logic [3:0]                  out_set_ones,
  output logic [1:0]                  out_cursor_pos,
  output logic                        out_running,
  output logic [1:0]                  out_meas_thousands,
  output logic [3:0]                  out_meas_hundreds,
  output logic [3:0]                  out_meas_tens,
  input  logic                        cfg_we,
  input  logic [csr_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [csr_pkg::CFG_DW-1:0]  cfg_wdata
);
  import csr_pkg::*;

  csr_cfg_t    cfg;
  csr_result_t res;
  csr_result_t res_r;
  logic        in_vld_r, out_vld_r;
  logic [7:0]  act_r, smp_r;
  logic        fire, in_load;

  csr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  csr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .action (act_r),
    .sample (smp_r),
    .cfg    (cfg),
    .res    (res)
  );

  // pass runs when a word waits, digits are ready and the result slot frees
  assign fire     = in_vld_r && !cfg.conv_busy && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_load  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      act_r <= in_action;
      smp_r <= in_adc_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  assign out_valid          = out_vld_r;
  assign out_dac_code       = res_r.dac_code;
  assign out_set_thousands  = res_r.set_digits[3];
  assign out_set_hundreds   = res_r.set_digits[2];
  assign out_set_tens       = res_r.set_digits[1];
  assign out_set_ones       = res_r.set_digits[0];
  assign out_cursor_pos     = res_r.cursor_pos;
  assign out_running        = res_r.running;
  assign out_meas_thousands = res_r.meas.thousands;
  assign out_meas_hundreds  = res_r.meas.hundreds;
  assign out_meas_tens      = res_r.meas.tens;

  // stall is only raised while a word is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("stall without a held word");

  // a held word waits out the digit conversion
  a_conv_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && cfg.conv_busy |=> in_vld_r)
    else $error("word lost during conversion");

  // a pass always lands in the result register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("pass did not produce a result");

endmodule

[bench/regulator_shadow_pkg.sv]
`timescale 1ns / 1ps
package regulator_shadow_pkg;
  import csr_pkg::*;

  // key codes with no function
  localparam logic [7:0] KEY_IDLE = 8'hFF;
  localparam logic [7:0] KEY_NULL = 8'h00;

  // one result word, field by field
  typedef struct packed {
    logic [7:0] dac;
    logic [3:0] sth;
    logic [3:0] shu;
    logic [3:0] ste;
    logic [3:0] son;
    logic [1:0] cur;
    logic       run;
    logic [1:0] mth;
    logic [3:0] mhu;
    logic [3:0] mte;
  } loop_result_t;

  class regulator_shadow;
    logic [13:0]  lim_lo, lim_hi, home_sp;
    logic [7:0]   ceil_code, floor_code, idle_code;
    logic [3:0]   dig [4];
    logic [1:0]   cursor;
    logic         running;
    logic [7:0]   drive;
    loop_result_t due_words [$];
    int           errors;

    function new();
      errors = 0;
      lim_lo = RST_SET_MIN;
      lim_hi = RST_SET_MAX;
      ceil_code = RST_CEILING;
      floor_code = RST_FLOOR;
      idle_code = RST_EDIT_DAC;
      home_sp = 14'd20;
      enter_edit();
    endfunction

    // split a binary setpoint into digits, clamped to four digits
    function void load_digits(int v);
      if (v > int'(SETPOINT_TOP)) v = int'(SETPOINT_TOP);
      dig[3] = 4'(v / 1000);
      dig[2] = 4'((v / 100) % 10);
      dig[1] = 4'((v / 10) % 10);
      dig[0] = 4'(v % 10);
    endfunction

    function int sp_value();
      return int'(dig[3]) * 1000 + int'(dig[2]) * 100 + int'(dig[1]) * 10 + int'(dig[0]);
    endfunction

    // setpoint / 10, rounded half up
    function int target_now();
      return int'(dig[3]) * 100 + int'(dig[2]) * 10 + int'(dig[1]) +
             ((dig[0] >= 4'd5) ? 1 : 0);
    endfunction

    function logic [7:0] target_code();
      int t;
      t = target_now();
      return (t > 255) ? 8'hFF : 8'(t);
    endfunction

    function void enter_edit();
      load_digits(int'(home_sp));
      cursor = 2'd0;
      running = 1'b0;
      drive = idle_code;
    endfunction

    function void write_reg(csr_reg_t idx, logic [13:0] val);
      case (idx)
        CFG_SET_MIN:          lim_lo = val;
        CFG_SET_MAX:          lim_hi = val;
        CFG_DAC_CEILING:      ceil_code = val[7:0];
        CFG_DAC_FLOOR:        floor_code = val[7:0];
        CFG_EDIT_DAC_CODE:    idle_code = val[7:0];
        CFG_DEFAULT_SETPOINT: home_sp = val;
        default: ;
      endcase
    endfunction

    // one accepted loop pass: update the state and queue the result word
    function void note_pass(logic [7:0] key, logic [7:0] sample);
      loop_result_t w;
      logic [3:0]   trial [4];
      int           c, v, t, m, stepv, sp;
      bit           up;
      w = '0;
      if (!running) begin
        w.dac = idle_code;
        if (key == KEY_INC || key == KEY_DEC) begin
          trial = dig;
          c = int'(cursor);
          if (key == KEY_INC) trial[c] = (trial[c] >= 4'd9) ? 4'd0 : trial[c] + 4'd1;
          else trial[c] = (trial[c] == 4'd0) ? 4'd9 : trial[c] - 4'd1;
          v = int'(trial[3]) * 1000 + int'(trial[2]) * 100 + int'(trial[1]) * 10 +
              int'(trial[0]);
          if (v <= int'(lim_hi) && v >= int'(lim_lo)) dig[c] = trial[c];
        end else if (key == KEY_NEXT) begin
          cursor = cursor + 2'd1;
        end else if (key == KEY_PREV) begin
          cursor = cursor - 2'd1;
        end else if (key == KEY_MODE) begin
          running = 1'b1;
          drive = target_code();
        end
      end else begin
        // one count of drive toward the target, then the key
        t = target_now();
        m = int'(sample) * 10;
        w.mth = 2'(m / 1000);
        w.mhu = 4'((m / 100) % 10);
        w.mte = 4'((m / 10) % 10);
        if (int'(sample) < t) begin
          if (drive < ceil_code) drive = drive + 8'd1;
        end else if (int'(sample) > t) begin
          if (drive > floor_code) drive = drive - 8'd1;
        end
        w.dac = drive;
        if (key == KEY_MODE) begin
          enter_edit();
        end else begin
          stepv = 0;
          up = 1'b0;
          case (key)
            KEY_INC:   begin stepv = 1;   up = 1'b1; end
            KEY_DEC:   stepv = 1;
            KEY_NEXT:  begin stepv = 100; up = 1'b1; end
            KEY_PREV:  stepv = 100;
            KEY_INC10: begin stepv = 10;  up = 1'b1; end
            KEY_DEC10: stepv = 10;
            default: ;
          endcase
          if (stepv != 0) begin
            sp = sp_value();
            if (up) begin
              if (sp + stepv <= int'(lim_hi) && sp + stepv <= int'(SETPOINT_TOP))
                load_digits(sp + stepv);
            end else if (sp >= int'(lim_lo) + stepv) begin
              load_digits(sp - stepv);
            end
            drive = target_code();
          end
        end
      end
      w.sth = dig[3];
      w.shu = dig[2];
      w.ste = dig[1];
      w.son = dig[0];
      w.cur = cursor;
      w.run = running;
      due_words.push_back(w);
    endfunction

    function void field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare a delivered word against the oldest expected one
    function void check_word(loop_result_t got);
      loop_result_t want;
      if (due_words.size() == 0) begin
        $display("%0t: result word arrived with nothing expected", $time);
        errors++;
        return;
      end
      want = due_words.pop_front();
      field("dac_code", want.dac, got.dac);
      field("set_thousands", want.sth, got.sth);
      field("set_hundreds", want.shu, got.shu);
      field("set_tens", want.ste, got.ste);
      field("set_ones", want.son, got.son);
      field("cursor_pos", want.cur, got.cur);
      field("running", want.run, got.run);
      field("meas_thousands", want.mth, got.mth);
      field("meas_hundreds", want.mhu, got.mhu);
      field("meas_tens", want.mte, got.mte);
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import csr_pkg::*;
  import regulator_shadow_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [7:0] in_action, in_adc_sample;
  logic out_valid, out_stall;
  logic [7:0] out_dac_code;
  logic [3:0] out_set_thousands, out_set_hundreds, out_set_tens, out_set_ones;
  logic [1:0] out_cursor_pos;
  logic out_running;
  logic [1:0] out_meas_thousands;
  logic [3:0] out_meas_hundreds, out_meas_tens;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  regulator_shadow shadow;
  loop_result_t seen;
  bit hold_req = 1'b0;
  int drift_left = 0;
  logic [7:0] drift_level = 8'h00;
  int burst_left = 0;

  current_setpoint_regulator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_adc_sample(in_adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dac_code(out_dac_code),
    .out_set_thousands(out_set_thousands), .out_set_hundreds(out_set_hundreds),
    .out_set_tens(out_set_tens), .out_set_ones(out_set_ones),
    .out_cursor_pos(out_cursor_pos), .out_running(out_running),
    .out_meas_thousands(out_meas_thousands), .out_meas_hundreds(out_meas_hundreds),
    .out_meas_tens(out_meas_tens),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check every word taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{dac: out_dac_code, sth: out_set_thousands, shu: out_set_hundreds,
               ste: out_set_tens, son: out_set_ones, cur: out_cursor_pos,
               run: out_running, mth: out_meas_thousands, mhu: out_meas_hundreds,
               mte: out_meas_tens};
      shadow.check_word(seen);
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver_side
    int hold_left, mode_left, stall_mode;
    hold_left = 0;
    mode_left = 0;
    stall_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 59;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 4) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // offer one word at a falling edge and hold it until taken
  task automatic send_word(input logic [7:0] key, input logic [7:0] sample);
    in_valid <= 1'b1;
    in_action <= key;
    in_adc_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_pass(key, sample);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.due_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input csr_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DW'(val);
    shadow.write_reg(idx, 14'(val));
  endtask

  task automatic program_regs(input int unsigned lo, hi, ceil, flr, idle, home);
    put_reg(CFG_SET_MIN, lo);
    put_reg(CFG_SET_MAX, hi);
    put_reg(CFG_DAC_CEILING, ceil);
    put_reg(CFG_DAC_FLOOR, flr);
    put_reg(CFG_EDIT_DAC_CODE, idle);
    put_reg(CFG_DEFAULT_SETPOINT, home);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random word: mostly samples near the target, with drift stretches in run mode
  task automatic pick_word(output logic [7:0] key, output logic [7:0] sample);
    int r, t;
    if (drift_left > 0) begin
      drift_left--;
      key = KEY_IDLE;
      sample = drift_level;
      return;
    end
    if (shadow.running && $urandom_range(0, 29) == 0) begin
      drift_left = $urandom_range(20, 150);
      drift_level = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end
    r = $urandom_range(0, 99);
    if (r < 40) key = KEY_IDLE;
    else if (r < 43) key = KEY_NULL;
    else if (r < 46) key = 8'($urandom_range(int'(KEY_DEC10) + 1, int'(KEY_IDLE) - 1));
    else if (r < 52) key = KEY_MODE;
    else begin
      case ($urandom_range(0, 5))
        0: key = KEY_INC;
        1: key = KEY_DEC;
        2: key = KEY_NEXT;
        3: key = KEY_PREV;
        4: key = KEY_INC10;
        default: key = KEY_DEC10;
      endcase
    end
    t = shadow.target_now() + $urandom_range(0, 6) - 3;
    case ($urandom_range(0, 9))
      6, 7: sample = 8'($urandom_range(0, 255));
      8: sample = 8'h00;
      9: sample = 8'hFF;
      default: sample = (t < 0) ? 8'h00 : (t > 255) ? 8'hFF : 8'(t);
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] k, s;
    int gap;
    shadow = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = KEY_IDLE;
    in_adc_sample = 8'h00;
    cfg_we = 1'b0;
    cfg_addr = CFG_SET_MIN;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ignored codes, digit wrap, limits, cursor, run-mode steps
    send_word(KEY_IDLE, 8'h00);
    send_word(KEY_NULL, 8'hFF);
    send_word(KEY_INC10, 8'h55);
    send_word(8'd200, 8'hAA);
    send_word(KEY_DEC, 8'h00);
    send_word(KEY_INC, 8'h00);
    send_word(KEY_PREV, 8'h00);
    send_word(KEY_INC, 8'h00);
    send_word(KEY_INC, 8'h00);
    send_word(KEY_NEXT, 8'h00);
    send_word(KEY_NEXT, 8'h00);
    send_word(KEY_DEC, 8'h00);
    send_word(KEY_MODE, 8'h00);
    send_word(KEY_IDLE, 8'h00);
    send_word(KEY_IDLE, 8'hFF);
    send_word(KEY_IDLE, 8'(shadow.target_now()));
    send_word(KEY_INC, 8'd100);
    send_word(KEY_INC10, 8'd100);
    send_word(KEY_DEC10, 8'd100);
    send_word(KEY_NEXT, 8'd100);
    send_word(KEY_PREV, 8'd100);
    send_word(8'd8, 8'd100);
    send_word(KEY_MODE, 8'd100);

    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: program_regs(0, 16383, 255, 0, 255, 16383);
          2: program_regs(0, 0, 0, 255, 0, 0);
          3: program_regs(1500, 1600, 200, 50, 128, 1550);
          8: program_regs(RST_SET_MIN, RST_SET_MAX, RST_CEILING, RST_FLOOR,
                          RST_EDIT_DAC, 20);
          default: begin
            gap = $urandom_range(0, 3000);
            program_regs(gap, gap + $urandom_range(0, 6999), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 9999));
          end
        endcase
      end
      // over-range default and setpoint at the top: saturated drive, refused steps
      if (p == 1) begin
        if (!shadow.running) send_word(KEY_MODE, 8'h00);
        send_word(KEY_MODE, 8'h00);
        send_word(KEY_MODE, 8'h00);
        send_word(KEY_IDLE, 8'hFF);
        send_word(KEY_INC, 8'hFF);
        send_word(KEY_DEC10, 8'hFF);
        send_word(KEY_INC10, 8'hFF);
        send_word(KEY_NEXT, 8'hFF);
        send_word(KEY_MODE, 8'hFF);
      end
      // long receiver hold-off while the sender keeps offering
      if (p % 3 == 1) begin
        hold_req = 1'b1;
        burst_left = 40;
      end
      for (int n = 0; n < 130; n++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 5);
          if (gap > 0) idle_gap(gap);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pick_word(k, s);
        send_word(k, s);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (shadow.errors == 0 && shadow.due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[current_setpoint_regulator_unit.f]
sv/csr_pkg.sv
sv/csr_cfg.sv
sv/csr_core.sv
sv/current_setpoint_regulator_unit.sv
bench/regulator_shadow_pkg.sv
bench/tb_top.sv
